// File: sv/bmdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bit matrix degree tracker.
package bmdt_pkg;

  localparam int ROW_W = 6;
  localparam int COL_W = 6;
  localparam int DEG_W = 7;
  localparam int CNT_W = 13;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;

  typedef logic [CFG_W-1:0] cfg_val_t;
  typedef logic [DEG_W-1:0] deg_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_DUPLICATE    = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_e;

  localparam cfg_idx_t CFG_ROWS_IN_USE = 1'b0;
  localparam cfg_idx_t CFG_COLS_IN_USE = 1'b1;

  localparam cfg_val_t CFG_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } in_item_t;

  typedef struct packed {
    logic       was_set;
    logic [1:0] status;
    deg_t       row_degree;
    deg_t       col_degree;
    deg_t       max_row_degree;
    deg_t       max_col_degree;
    cnt_t       total_set;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic eval;
    logic scan;
    logic load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } dp_status_t;

endpackage

// File: sv/bmdt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences read, update, rescan and result handoff.
module bmdt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  bmdt_pkg::dp_status_t   status_i,
  output bmdt_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) & in_valid_i;
    cmd_o.read    = (state_q == ST_READ);
    cmd_o.eval    = (state_q == ST_EVAL);
    cmd_o.scan    = (state_q == ST_SCAN);
    cmd_o.load    = (state_q == ST_DONE) & out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          state_q <= status_i.need_scan ? ST_SCAN : ST_DONE;
        end
        ST_SCAN: begin
          if (status_i.scan_done) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/bmdt_dpath.sv
`timescale 1ns / 1ps
// Datapath: matrix and degree memories, maxima, set count, rescan and result register.
module bmdt_dpath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmdt_pkg::ctrl_cmd_t  cmd_i,
  output bmdt_pkg::dp_status_t status_o,
  input  bmdt_pkg::in_item_t   in_item_i,
  input  bmdt_pkg::cfg_val_t   rows_in_use_i,
  input  bmdt_pkg::cfg_val_t   cols_in_use_i,
  output bmdt_pkg::out_item_t  out_item_o
);

  // Indexes beyond the field range are never addressed, so storage stops there.
  localparam int IDX_LIM_R = 1 << bmdt_pkg::ROW_W;
  localparam int IDX_LIM_C = 1 << bmdt_pkg::COL_W;
  localparam int NR  = (MAX_ROWS < IDX_LIM_R) ? MAX_ROWS : IDX_LIM_R;
  localparam int NC  = (MAX_COLS < IDX_LIM_C) ? MAX_COLS : IDX_LIM_C;
  localparam int RAW = $clog2(NR);
  localparam int CAW = $clog2(NC);
  localparam int SN  = (NR > NC) ? NR : NC;
  localparam int SCW = $clog2(SN + 1);

  typedef logic [SCW-1:0] scan_cnt_t;

  localparam bmdt_pkg::cfg_val_t ROW_LIM = bmdt_pkg::cfg_val_t'(NR);
  localparam bmdt_pkg::cfg_val_t COL_LIM = bmdt_pkg::cfg_val_t'(NC);
  localparam scan_cnt_t SCAN_END = scan_cnt_t'(SN);
  localparam scan_cnt_t SCAN_NR  = scan_cnt_t'(NR);
  localparam scan_cnt_t SCAN_NC  = scan_cnt_t'(NC);

  // Memories; entries not yet written read as zero through the valid bits
  logic [NC-1:0]        mat_mem   [NR];
  bmdt_pkg::deg_t       rdeg_mem  [NR];
  bmdt_pkg::deg_t       cdeg_mem  [NC];
  logic [NR-1:0]        mat_vld_q;
  logic [NR-1:0]        rdeg_vld_q;
  logic [NC-1:0]        cdeg_vld_q;

  logic [NC-1:0]        mat_rd_q;
  logic                 mat_vld_rd_q;
  bmdt_pkg::deg_t       rdeg_rd_q;
  logic                 rdeg_vld_rd_q;
  bmdt_pkg::deg_t       cdeg_rd_q;
  logic                 cdeg_vld_rd_q;

  bmdt_pkg::in_item_t   item_q;
  logic                 in_range_q;
  bmdt_pkg::deg_t       max_row_q;
  bmdt_pkg::deg_t       max_col_q;
  bmdt_pkg::cnt_t       total_q;

  scan_cnt_t            scan_cnt_q;
  logic                 run_row_q;
  logic                 run_col_q;
  logic                 srv_q;
  logic                 scv_q;

  logic                 res_was_q;
  logic [1:0]           res_status_q;
  bmdt_pkg::deg_t       res_rd_q;
  bmdt_pkg::deg_t       res_cd_q;
  bmdt_pkg::out_item_t  res_q;

  logic [RAW-1:0]       row_idx;
  logic [CAW-1:0]       col_idx;
  logic [RAW-1:0]       rdeg_addr;
  logic [CAW-1:0]       cdeg_addr;
  logic                 rdeg_re;
  logic                 cdeg_re;
  logic                 scan_issue_r;
  logic                 scan_issue_c;
  logic                 in_range;

  logic [NC-1:0]        row_cur;
  logic [NC-1:0]        row_wdata;
  bmdt_pkg::deg_t       rd_cur;
  bmdt_pkg::deg_t       cd_cur;
  bmdt_pkg::deg_t       rd_new;
  bmdt_pkg::deg_t       cd_new;
  bmdt_pkg::deg_t       scan_rd;
  bmdt_pkg::deg_t       scan_cd;
  logic                 was;
  logic                 is_add;
  logic                 is_rem;
  logic                 do_add;
  logic                 do_rem;
  logic                 do_write;
  logic                 need_row;
  logic                 need_col;
  logic [1:0]           status_code;

  assign row_idx = item_q.row[RAW-1:0];
  assign col_idx = item_q.col[CAW-1:0];

  assign in_range = (bmdt_pkg::cfg_val_t'(in_item_i.row) < rows_in_use_i) &&
                    (bmdt_pkg::cfg_val_t'(in_item_i.row) < ROW_LIM) &&
                    (bmdt_pkg::cfg_val_t'(in_item_i.col) < cols_in_use_i) &&
                    (bmdt_pkg::cfg_val_t'(in_item_i.col) < COL_LIM);

  // Degree read ports: addressed entry on a read, sweep index during a rescan
  assign scan_issue_r = cmd_i.scan & (scan_cnt_q < SCAN_NR);
  assign scan_issue_c = cmd_i.scan & (scan_cnt_q < SCAN_NC);
  assign rdeg_re      = cmd_i.read | scan_issue_r;
  assign cdeg_re      = cmd_i.read | scan_issue_c;
  assign rdeg_addr    = cmd_i.read ? row_idx : scan_cnt_q[RAW-1:0];
  assign cdeg_addr    = cmd_i.read ? col_idx : scan_cnt_q[CAW-1:0];

  // Update evaluation
  always_comb begin
    row_cur   = mat_vld_rd_q ? mat_rd_q : '0;
    rd_cur    = rdeg_vld_rd_q ? rdeg_rd_q : '0;
    cd_cur    = cdeg_vld_rd_q ? cdeg_rd_q : '0;
    was       = in_range_q & row_cur[col_idx];
    is_add    = (item_q.kind == bmdt_pkg::KIND_ADD);
    is_rem    = (item_q.kind == bmdt_pkg::KIND_REMOVE);
    do_add    = in_range_q & is_add & ~was;
    do_rem    = in_range_q & is_rem & was;
    do_write  = do_add | do_rem;
    row_wdata = row_cur;
    row_wdata[col_idx] = do_add;
    if (do_add) begin
      rd_new = rd_cur + bmdt_pkg::deg_t'(1);
      cd_new = cd_cur + bmdt_pkg::deg_t'(1);
    end else if (do_rem) begin
      rd_new = rd_cur - bmdt_pkg::deg_t'(1);
      cd_new = cd_cur - bmdt_pkg::deg_t'(1);
    end else begin
      rd_new = rd_cur;
      cd_new = cd_cur;
    end
    // only a remove from a row or column sitting at the maximum can lower it
    need_row = do_rem & (rd_cur == max_row_q);
    need_col = do_rem & (cd_cur == max_col_q);
    if (!in_range_q) begin
      status_code = bmdt_pkg::STATUS_OUT_OF_RANGE;
    end else if (is_add && was) begin
      status_code = bmdt_pkg::STATUS_DUPLICATE;
    end else begin
      status_code = bmdt_pkg::STATUS_OK;
    end
  end

  assign scan_rd = rdeg_vld_rd_q ? rdeg_rd_q : '0;
  assign scan_cd = cdeg_vld_rd_q ? cdeg_rd_q : '0;

  assign status_o.need_scan = need_row | need_col;
  assign status_o.scan_done = (scan_cnt_q == SCAN_END);

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      mat_rd_q     <= mat_mem[row_idx];
      mat_vld_rd_q <= mat_vld_q[row_idx];
    end
    if (rdeg_re) begin
      rdeg_rd_q     <= rdeg_mem[rdeg_addr];
      rdeg_vld_rd_q <= rdeg_vld_q[rdeg_addr];
    end
    if (cdeg_re) begin
      cdeg_rd_q     <= cdeg_mem[cdeg_addr];
      cdeg_vld_rd_q <= cdeg_vld_q[cdeg_addr];
    end
    if (cmd_i.eval && do_write) begin
      mat_mem[row_idx]  <= row_wdata;
      rdeg_mem[row_idx] <= rd_new;
      cdeg_mem[col_idx] <= cd_new;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q     <= in_item_i;
      in_range_q <= in_range;
    end
    if (cmd_i.eval) begin
      res_was_q    <= was;
      res_status_q <= status_code;
      res_rd_q     <= in_range_q ? rd_new : '0;
      res_cd_q     <= in_range_q ? cd_new : '0;
    end
    if (cmd_i.load) begin
      res_q.was_set        <= res_was_q;
      res_q.status         <= res_status_q;
      res_q.row_degree     <= res_rd_q;
      res_q.col_degree     <= res_cd_q;
      res_q.max_row_degree <= max_row_q;
      res_q.max_col_degree <= max_col_q;
      res_q.total_set      <= total_q;
    end
  end

  // Valid bits, maxima, count and rescan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_vld_q  <= '0;
      rdeg_vld_q <= '0;
      cdeg_vld_q <= '0;
      max_row_q  <= '0;
      max_col_q  <= '0;
      total_q    <= '0;
      scan_cnt_q <= '0;
      run_row_q  <= 1'b0;
      run_col_q  <= 1'b0;
      srv_q      <= 1'b0;
      scv_q      <= 1'b0;
    end else begin
      srv_q <= scan_issue_r;
      scv_q <= scan_issue_c;
      if (cmd_i.eval) begin
        scan_cnt_q <= '0;
        run_row_q  <= need_row;
        run_col_q  <= need_col;
        if (do_write) begin
          mat_vld_q[row_idx]  <= 1'b1;
          rdeg_vld_q[row_idx] <= 1'b1;
          cdeg_vld_q[col_idx] <= 1'b1;
        end
        if (do_add) begin
          total_q <= total_q + bmdt_pkg::cnt_t'(1);
          if (rd_new > max_row_q) max_row_q <= rd_new;
          if (cd_new > max_col_q) max_col_q <= cd_new;
        end else if (do_rem) begin
          total_q <= total_q - bmdt_pkg::cnt_t'(1);
          if (need_row) max_row_q <= '0;
          if (need_col) max_col_q <= '0;
        end
      end else if (cmd_i.scan) begin
        if (scan_cnt_q != SCAN_END) scan_cnt_q <= scan_cnt_q + scan_cnt_t'(1);
        if (run_row_q && srv_q && (scan_rd > max_row_q)) max_row_q <= scan_rd;
        if (run_col_q && scv_q && (scan_cd > max_col_q)) max_col_q <= scan_cd;
      end
    end
  end

  assign out_item_o = res_q;

  // A degree reported with a result never exceeds the maximum or the total
  a_row_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (res_q.row_degree <= res_q.max_row_degree))
    else $error("row degree above row maximum");

  a_col_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (res_q.col_degree <= res_q.max_col_degree))
    else $error("column degree above column maximum");

  a_max_le_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (bmdt_pkg::cnt_t'(res_q.max_row_degree) <= res_q.total_set))
    else $error("row maximum above set count");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (scan_cnt_q <= SCAN_END))
    else $error("rescan index ran past the end");

endmodule

// File: sv/bit_matrix_degree_tracker_top.sv
`timescale 1ns / 1ps
// Top level of the bit matrix degree tracker: configuration registers and unit wiring.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------
//  in       | in_valid_i / in_stall_o     | in_item_i  (kind, row, col)
//  out      | out_valid_o / out_stall_i   | out_item_o (was_set .. total_set)
//  cfg      | cfg_we_i                    | cfg_idx_i, cfg_wdata_i
//
// One item at a time: each transfer steps through accept, read, update and result.
// A remove from a row or column sitting at its maximum degree adds a sweep of
// the degree memories that finds the new maximum.
// Reset clears the matrix and counts at once through per-entry valid bits.
// A held result waits in the output register; a stalled output holds the
// controller in its handoff state before the next transfer is taken.
module bit_matrix_degree_tracker_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bmdt_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bmdt_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  bmdt_pkg::cfg_idx_t   cfg_idx_i,
  input  bmdt_pkg::cfg_val_t   cfg_wdata_i
);

  bmdt_pkg::cfg_val_t   rows_in_use_q;
  bmdt_pkg::cfg_val_t   cols_in_use_q;
  bmdt_pkg::ctrl_cmd_t  cmd;
  bmdt_pkg::dp_status_t dp_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_in_use_q <= bmdt_pkg::CFG_RESET;
      cols_in_use_q <= bmdt_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmdt_pkg::CFG_ROWS_IN_USE: rows_in_use_q <= cfg_wdata_i;
        bmdt_pkg::CFG_COLS_IN_USE: cols_in_use_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bmdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  bmdt_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .in_item_i     (in_item_i),
    .rows_in_use_i (rows_in_use_q),
    .cols_in_use_i (cols_in_use_q),
    .out_item_o    (out_item_o)
  );

endmodule
